>>> hw/rtl/pmsl_pkg.sv
// PLL M/N/P search: shared types and constants.
// Used by pmsl_div, pmsl_dp, pmsl_ctrl and pll_mnp_search_legacy.
`timescale 1ns / 1ps
package pmsl_pkg;

	localparam logic [2:0] REG_FAMILY     = 3'd0;
	localparam logic [2:0] REG_REF_CLK    = 3'd1;
	localparam logic [2:0] REG_MIN_VCO    = 3'd2;
	localparam logic [2:0] REG_MAX_VCO    = 3'd3;
	localparam logic [2:0] REG_PCLK_16    = 3'd4;
	localparam logic [2:0] REG_PCLK_32    = 3'd5;
	localparam logic [2:0] REG_PCLK_32_DH = 3'd6;

	localparam logic [1:0] DEPTH_16 = 2'd0;
	localparam logic [1:0] DEPTH_32 = 2'd1;

	localparam logic [17:0] OLD_T_LO  = 18'd100000;
	localparam logic [17:0] OLD_T_MID = 18'd140000;
	localparam logic [17:0] OLD_T_HI  = 18'd180000;
	localparam logic [17:0] NEW_T_LO  = 18'd110000;
	localparam logic [17:0] NEW_T_MID = 18'd170000;
	localparam logic [17:0] NEW_T_HI  = 18'd240000;

	localparam int DIV_R_W = 26;
	localparam int DIV_Q_W = 33;
	localparam logic [5:0] N_DIV_STEPS = 6'd8;
	localparam logic [5:0] G_DIV_STEPS = 6'd33;

	typedef struct packed {
		logic        family;
		logic [16:0] ref_clk;
		logic [19:0] min_vco;
		logic [19:0] max_vco;
		logic [19:0] pclk_16;
		logic [19:0] pclk_32;
		logic [19:0] pclk_32_dh;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic next_p;
		logic first_m;
		logic next_m;
		logic cap_mul;
		logic start_ndiv;
		logic cap_n;
		logic cap_gmul;
		logic start_gdiv;
		logic cap_got;
		logic upd;
		logic cap_filt;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic ref_zero;
		logic p_ok;
		logic p_last;
		logic m_last;
		logic n_ok;
		logic div_busy;
		logic better;
	} sts_t;

endpackage

>>> hw/rtl/pmsl_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on pmsl_pkg.
`timescale 1ns / 1ps
module pmsl_div import pmsl_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DIV_R_W-1:0] den,
	input  logic [DIV_R_W-1:0] rem_init,
	input  logic [DIV_Q_W-1:0] dividend,
	input  logic [5:0]         steps,
	output logic               busy,
	output logic [DIV_Q_W-1:0] quo
);

	logic [DIV_R_W-1:0] den_q;
	logic [DIV_R_W-1:0] rem_q;
	logic [DIV_Q_W-1:0] sh_q;
	logic [DIV_Q_W-1:0] quo_q;
	logic [5:0]         cnt_q;
	logic               busy_q;
	logic [DIV_R_W:0]   trial;
	logic               ge;

	assign trial = {rem_q, sh_q[DIV_Q_W-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= rem_init;
			sh_q  <= dividend;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? DIV_R_W'(trial - {1'b0, den_q}) : trial[DIV_R_W-1:0];
			sh_q  <= {sh_q[DIV_Q_W-2:0], 1'b0};
			quo_q <= {quo_q[DIV_Q_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;

endmodule

>>> hw/rtl/pmsl_dp.sv
// Datapath: request clamp, candidate arithmetic, best tracking, filter, result register.
// Depends on pmsl_pkg and pmsl_div.
`timescale 1ns / 1ps
module pmsl_dp import pmsl_pkg::*; #(
	parameter int M_MAX = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic [19:0] pixel_clock_khz,
	input  logic [1:0]  depth_code,
	input  logic        dual_head,
	output logic        found,
	output logic [4:0]  m_code,
	output logic [6:0]  n_code,
	output logic [4:0]  p_code,
	output logic [19:0] produced_clock_khz
);

	localparam int MW    = $clog2(M_MAX + 1);
	localparam int VM_W  = 31 + MW;
	localparam int NUM_W = VM_W + 1;
	localparam int TW    = 18 + MW;

	logic [27:0]      req_q;
	logic [1:0]       pidx_q;
	logic [MW-1:0]    m_q;
	logic [VM_W-1:0]  vm_q;
	logic [7:0]       n_q;
	logic [24:0]      gn_q;
	logic [32:0]      got_q;
	logic             found_q;
	logic [32:0]      berr_q;
	logic [MW-1:0]    bm_q;
	logic [7:0]       bn_q;
	logic [1:0]       bp_q;
	logic [32:0]      bgot_q;
	logic [1:0]       filt_q;

	logic [19:0]      ceil_khz;
	logic [27:0]      req_lo;
	logic [27:0]      req_d;
	logic [30:0]      vco;
	logic [NUM_W-1:0] num;
	logic [23:0]      ref129;
	logic [32:0]      req33;
	logic [32:0]      err;
	logic             div_start;
	logic [DIV_R_W-1:0] div_den;
	logic [DIV_R_W-1:0] div_rem;
	logic [DIV_Q_W-1:0] div_num;
	logic [5:0]       div_steps;
	logic             div_busy;
	logic [DIV_Q_W-1:0] div_quo;
	logic [17:0]      t_lo, t_mid, t_hi;
	logic [24:0]      fnum;
	logic [TW-1:0]    tm_lo, tm_mid, tm_hi;
	logic [MW-1:0]    bm_m1;

	always_comb begin
		ceil_khz = (depth_code == DEPTH_16) ? cfg.pclk_16 : cfg.pclk_32;
		if (dual_head && depth_code == DEPTH_32)
			ceil_khz = cfg.pclk_32_dh;
		req_lo = {pixel_clock_khz, 8'b0};
		if (req_lo < {3'b0, cfg.min_vco, 5'b0})
			req_lo = {3'b0, cfg.min_vco, 5'b0};
		req_d = (req_lo > {ceil_khz, 8'b0}) ? {ceil_khz, 8'b0} : req_lo;
	end

	assign vco    = {3'b0, req_q} << pidx_q;
	assign num    = {vm_q, 1'b0} + NUM_W'({cfg.ref_clk, 8'b0});
	assign ref129 = 24'({cfg.ref_clk, 7'b0}) + 24'(cfg.ref_clk);
	assign req33  = {5'b0, req_q};
	assign err    = (got_q >= req33) ? got_q - req33 : req33 - got_q;

	always_comb begin
		sts.ref_zero = cfg.ref_clk == 17'd0;
		sts.p_ok     = (vco >= {3'b0, cfg.min_vco, 8'b0}) && (vco <= {3'b0, cfg.max_vco, 8'b0});
		sts.p_last   = pidx_q == 2'd3;
		sts.m_last   = m_q == MW'(M_MAX);
		sts.n_ok     = (num >= NUM_W'({cfg.ref_clk, 12'b0})) &&
		               (num < NUM_W'({ref129, 9'b0}));
		sts.div_busy = div_busy;
		sts.better   = !found_q || (err < berr_q);
	end

	// N = round(2*vco*m / (512*ref)); clock = ref*N*256 / m, then >> P
	always_comb begin
		div_start = cmd.start_ndiv | cmd.start_gdiv;
		if (cmd.start_ndiv) begin
			div_den   = {cfg.ref_clk, 9'b0};
			div_rem   = num[33:8];
			div_num   = {num[7:0], 25'b0};
			div_steps = N_DIV_STEPS;
		end else begin
			div_den   = DIV_R_W'(m_q);
			div_rem   = '0;
			div_num   = {gn_q, 8'b0};
			div_steps = G_DIV_STEPS;
		end
	end

	pmsl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.den      (div_den),
		.rem_init (div_rem),
		.dividend (div_num),
		.steps    (div_steps),
		.busy     (div_busy),
		.quo      (div_quo)
	);

	always_comb begin
		if (cfg.family) begin
			t_lo = NEW_T_LO; t_mid = NEW_T_MID; t_hi = NEW_T_HI;
		end else begin
			t_lo = OLD_T_LO; t_mid = OLD_T_MID; t_hi = OLD_T_HI;
		end
		fnum   = 25'(cfg.ref_clk) * 25'(bn_q);
		tm_lo  = TW'(t_lo) * TW'(bm_q);
		tm_mid = TW'(t_mid) * TW'(bm_q);
		tm_hi  = TW'(t_hi) * TW'(bm_q);
		bm_m1  = bm_q - MW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			pidx_q  <= '0;
			m_q     <= '0;
		end else begin
			if (cmd.load) begin
				found_q <= 1'b0;
				pidx_q  <= '0;
			end else if (cmd.next_p)
				pidx_q <= pidx_q + 2'd1;
			if (cmd.first_m)
				m_q <= MW'(2);
			else if (cmd.next_m)
				m_q <= m_q + MW'(1);
			if (cmd.upd)
				found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			req_q <= req_d;
		if (cmd.cap_mul)
			vm_q <= VM_W'(vco) * VM_W'(m_q);
		if (cmd.cap_n)
			n_q <= div_quo[7:0];
		if (cmd.cap_gmul)
			gn_q <= 25'(cfg.ref_clk) * 25'(n_q);
		if (cmd.cap_got)
			got_q <= div_quo >> pidx_q;
		if (cmd.upd) begin
			berr_q <= err;
			bm_q   <= m_q;
			bn_q   <= n_q;
			bp_q   <= pidx_q;
			bgot_q <= got_q;
		end
		if (cmd.cap_filt) begin
			priority if (32'(fnum) >= 32'(tm_hi))
				filt_q <= 2'd3;
			else if (32'(fnum) >= 32'(tm_mid))
				filt_q <= 2'd2;
			else if (32'(fnum) >= 32'(tm_lo))
				filt_q <= 2'd1;
			else
				filt_q <= 2'd0;
		end
		if (cmd.out_load) begin
			if (found_q) begin
				found              <= 1'b1;
				m_code             <= 5'(bm_m1);
				n_code             <= 7'(bn_q - 8'd1);
				p_code             <= {filt_q, 3'((4'd1 << bp_q) - 4'd1)};
				produced_clock_khz <= bgot_q[27:8];
			end else begin
				found              <= 1'b0;
				m_code             <= '0;
				n_code             <= '0;
				p_code             <= '0;
				produced_clock_khz <= '0;
			end
		end
	end

endmodule

>>> hw/rtl/pmsl_ctrl.sv
// Controller FSM: sequences the P/M candidate search and the result handshake.
// Depends on pmsl_pkg.
`timescale 1ns / 1ps
module pmsl_ctrl import pmsl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_PCHK   = 4'd1;
	localparam logic [3:0] S_MUL    = 4'd2;
	localparam logic [3:0] S_NCHK   = 4'd3;
	localparam logic [3:0] S_NWAIT  = 4'd4;
	localparam logic [3:0] S_GMUL   = 4'd5;
	localparam logic [3:0] S_GSTART = 4'd6;
	localparam logic [3:0] S_GWAIT  = 4'd7;
	localparam logic [3:0] S_CMP    = 4'd8;
	localparam logic [3:0] S_ADV    = 4'd9;
	localparam logic [3:0] S_FILT   = 4'd10;
	localparam logic [3:0] S_OUT    = 4'd11;

	logic [3:0] state_q, state_d;
	logic       out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_PCHK;
				end
			end
			S_PCHK: begin
				if (sts.ref_zero || (!sts.p_ok && sts.p_last))
					state_d = S_FILT;
				else if (sts.p_ok) begin
					cmd.first_m = 1'b1;
					state_d     = S_MUL;
				end else
					cmd.next_p = 1'b1;
			end
			S_MUL: begin
				cmd.cap_mul = 1'b1;
				state_d     = S_NCHK;
			end
			S_NCHK: begin
				if (sts.n_ok) begin
					cmd.start_ndiv = 1'b1;
					state_d        = S_NWAIT;
				end else
					state_d = S_ADV;
			end
			S_NWAIT: begin
				if (!sts.div_busy) begin
					cmd.cap_n = 1'b1;
					state_d   = S_GMUL;
				end
			end
			S_GMUL: begin
				cmd.cap_gmul = 1'b1;
				state_d      = S_GSTART;
			end
			S_GSTART: begin
				cmd.start_gdiv = 1'b1;
				state_d        = S_GWAIT;
			end
			S_GWAIT: begin
				if (!sts.div_busy) begin
					cmd.cap_got = 1'b1;
					state_d     = S_CMP;
				end
			end
			S_CMP: begin
				cmd.upd = sts.better;
				state_d = S_ADV;
			end
			S_ADV: begin
				if (!sts.m_last) begin
					cmd.next_m = 1'b1;
					state_d    = S_MUL;
				end else if (sts.p_last)
					state_d = S_FILT;
				else begin
					cmd.next_p = 1'b1;
					state_d    = S_PCHK;
				end
			end
			S_FILT: begin
				cmd.cap_filt = 1'b1;
				state_d      = S_OUT;
			end
			S_OUT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("result register overwritten while held");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.start_ndiv || cmd.start_gdiv) |-> !sts.div_busy)
		else $error("divider started while busy");
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("second transaction taken during search");
	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid)
		else $error("loaded result not presented");

endmodule

>>> hw/rtl/pll_mnp_search_legacy.sv
// Top level of the PLL M/N/P divider search: configuration registers, controller, datapath.
// Depends on pmsl_pkg, pmsl_ctrl, pmsl_dp.
`timescale 1ns / 1ps
// One request is taken at a time and yields one result transaction. For each
// post-divider whose VCO is in range, 31 reference-divider candidates are tried;
// each one with N in 8..128 uses the shared restoring divider twice, with 8
// steps for N and 33 steps for the produced clock. The input side stalls
// until the result is in the output register; a held result does not block
// the next request.
module pll_mnp_search_legacy import pmsl_pkg::*; #(
	parameter int M_MAX = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [19:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [19:0] pixel_clock_khz,
	input  logic [1:0]  depth_code,
	input  logic        dual_head,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        found,
	output logic [4:0]  m_code,
	output logic [6:0]  n_code,
	output logic [4:0]  p_code,
	output logic [19:0] produced_clock_khz
);

	cfg_t cfg_q;
	cmd_t cmd;
	sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.family     <= 1'b1;
			cfg_q.ref_clk    <= 17'd27000;
			cfg_q.min_vco    <= 20'd50000;
			cfg_q.max_vco    <= 20'd310000;
			cfg_q.pclk_16    <= 20'd136000;
			cfg_q.pclk_32    <= 20'd136000;
			cfg_q.pclk_32_dh <= 20'd136000;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_FAMILY:     cfg_q.family     <= cfg_wdata[0];
				REG_REF_CLK:    cfg_q.ref_clk    <= cfg_wdata[16:0];
				REG_MIN_VCO:    cfg_q.min_vco    <= cfg_wdata;
				REG_MAX_VCO:    cfg_q.max_vco    <= cfg_wdata;
				REG_PCLK_16:    cfg_q.pclk_16    <= cfg_wdata;
				REG_PCLK_32:    cfg_q.pclk_32    <= cfg_wdata;
				REG_PCLK_32_DH: cfg_q.pclk_32_dh <= cfg_wdata;
				default: ;
			endcase
		end
	end

	pmsl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	pmsl_dp #(.M_MAX(M_MAX)) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg                (cfg_q),
		.cmd                (cmd),
		.sts                (sts),
		.pixel_clock_khz    (pixel_clock_khz),
		.depth_code         (depth_code),
		.dual_head          (dual_head),
		.found              (found),
		.m_code             (m_code),
		.n_code             (n_code),
		.p_code             (p_code),
		.produced_clock_khz (produced_clock_khz)
	);

endmodule

>>> sim/tb_top.sv
// Testbench for pll_mnp_search_legacy: directed and random divider-search requests,
// checked against an in-bench predictor through a small scoreboard class. Needs pmsl_pkg.
`timescale 1ns / 1ps

class mnp_scoreboard;
	typedef struct {
		logic        found;
		logic [4:0]  m_code;
		logic [6:0]  n_code;
		logic [4:0]  p_code;
		logic [19:0] clk_khz;
	} setting_t;

	setting_t pending[$];
	int       errors;
	int       checked;

	bit        family;
	bit [16:0] ref_khz;
	bit [19:0] vco_min, vco_max, ceil16, ceil32, ceil32dh;

	function void reset_regs();
		family = 1; ref_khz = 27000; vco_min = 50000; vco_max = 310000;
		ceil16 = 136000; ceil32 = 136000; ceil32dh = 136000;
	endfunction

	function void write_reg(logic [2:0] idx, logic [19:0] val);
		case (idx)
			pmsl_pkg::REG_FAMILY:     family = val[0];
			pmsl_pkg::REG_REF_CLK:    ref_khz = val[16:0];
			pmsl_pkg::REG_MIN_VCO:    vco_min = val;
			pmsl_pkg::REG_MAX_VCO:    vco_max = val;
			pmsl_pkg::REG_PCLK_16:    ceil16 = val;
			pmsl_pkg::REG_PCLK_32:    ceil32 = val;
			pmsl_pkg::REG_PCLK_32_DH: ceil32dh = val;
			default: ;
		endcase
	endfunction

	function setting_t search(logic [19:0] pix, logic [1:0] depth, logic dual);
		setting_t r;
		longint unsigned ceil_k, req, vco, n, got, err, best_err, num;
		longint unsigned bm, bn, bp, tlo, tmid, thi, filt;
		bit hit;
		ceil_k = (depth == pmsl_pkg::DEPTH_16) ? longint'(ceil16) : longint'(ceil32);
		if (dual && depth == pmsl_pkg::DEPTH_32) ceil_k = longint'(ceil32dh);
		req = longint'(pix) << 8;
		if (req < (longint'(vco_min) << 5)) req = longint'(vco_min) << 5;
		if (req > (ceil_k << 8)) req = ceil_k << 8;
		hit = 0; best_err = 0; bm = 0; bn = 0; bp = 0;
		if (ref_khz != 0) begin
			for (longint unsigned p = 1; p <= 8; p = p << 1) begin
				vco = req * p;
				if (vco < (longint'(vco_min) << 8) || vco > (longint'(vco_max) << 8))
					continue;
				for (longint unsigned m = 2; m <= 32; m++) begin
					n = (vco * m * 2 + (longint'(ref_khz) << 8)) / (longint'(ref_khz) << 9);
					if (n < 8 || n > 128) continue;
					got = ((longint'(ref_khz) * n) << 8) / (m * p);
					err = (got > req) ? got - req : req - got;
					if (!hit || err < best_err) begin
						hit = 1; best_err = err; bm = m; bn = n; bp = p;
					end
				end
			end
		end
		r = '{0, 0, 0, 0, 0};
		if (!hit) return r;
		num = longint'(ref_khz) * bn;
		if (family == 0) begin
			tlo = 100000; tmid = 140000; thi = 180000;
		end else begin
			tlo = 110000; tmid = 170000; thi = 240000;
		end
		filt = 0;
		if (num >= thi * bm) filt = 3;
		else if (num >= tmid * bm) filt = 2;
		else if (num >= tlo * bm) filt = 1;
		r.found = 1;
		r.m_code = 5'(bm - 1);
		r.n_code = 7'(bn - 1);
		r.p_code = {filt[1:0], 3'(bp - 1)};
		r.clk_khz = 20'(num / (bm * bp));
		return r;
	endfunction

	function void note_request(logic [19:0] pix, logic [1:0] depth, logic dual);
		pending.push_back(search(pix, depth, dual));
	endfunction

	function void check_result(logic f, logic [4:0] m, logic [6:0] n, logic [4:0] p,
			logic [19:0] c);
		setting_t e;
		if (pending.size() == 0) begin
			$error("result with no request waiting");
			errors++;
			return;
		end
		e = pending.pop_front();
		checked++;
		if (f !== e.found) begin
			$error("found: expected %0d actual %0d", e.found, f); errors++;
		end
		if (m !== e.m_code) begin
			$error("m_code: expected %0d actual %0d", e.m_code, m); errors++;
		end
		if (n !== e.n_code) begin
			$error("n_code: expected %0d actual %0d", e.n_code, n); errors++;
		end
		if (p !== e.p_code) begin
			$error("p_code: expected %0d actual %0d", e.p_code, p); errors++;
		end
		if (c !== e.clk_khz) begin
			$error("produced_clock_khz: expected %0d actual %0d", e.clk_khz, c); errors++;
		end
	endfunction
endclass

module tb_top;
	import pmsl_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_wr_en = 0;
	logic [2:0]  cfg_index = '0;
	logic [19:0] cfg_wdata = '0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [19:0] pixel_clock_khz = '0;
	logic [1:0]  depth_code = '0;
	logic        dual_head = 0;
	logic        out_valid;
	logic        out_stall = 0;
	logic        found;
	logic [4:0]  m_code;
	logic [6:0]  n_code;
	logic [4:0]  p_code;
	logic [19:0] produced_clock_khz;

	mnp_scoreboard sb;
	int  n_req;
	bit  rx_quiet;

	pll_mnp_search_legacy u_top (.*);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	function automatic int gap_len();
		int r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 90) return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [19:0] val);
		@(posedge clk);
		cfg_wr_en <= 1; cfg_index <= idx; cfg_wdata <= val;
		@(posedge clk);
		cfg_wr_en <= 0;
		sb.write_reg(idx, val);
	endtask

	task automatic send_request(logic [19:0] pix, logic [1:0] depth, logic dual);
		int g = gap_len();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1; pixel_clock_khz <= pix; depth_code <= depth; dual_head <= dual;
		do @(posedge clk); while (in_stall);
		sb.note_request(pix, depth, dual);
		n_req++;
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic random_request();
		logic [19:0] pix;
		int r = $urandom_range(0, 9);
		if (r < 7) pix = 20'($urandom_range(5000, 400000));
		else if (r < 8) pix = 20'($urandom_range(0, 8000));
		else pix = 20'($urandom);
		send_request(pix, 2'($urandom_range(0, 3)), 1'($urandom));
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(found, m_code, n_code, p_code, produced_clock_khz);
	end

	always @(posedge clk) begin
		if (rx_quiet) out_stall <= 0;
		else out_stall <= ($urandom_range(0, 99) < 30);
	end

	initial begin
		sb = new();
		sb.reset_regs();
		rx_quiet = 1;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// directed: reset settings
		send_request(20'd0, DEPTH_16, 0);
		send_request(20'hFFFFF, DEPTH_32, 1);
		send_request(20'd25175, DEPTH_16, 0);
		send_request(20'd65000, DEPTH_32, 0);
		send_request(20'd108000, 2'd2, 1);
		send_request(20'd135000, 2'd3, 1);
		send_request(20'd74250, DEPTH_32, 1);
		drain();
		rx_quiet = 0;

		// older family, dual ceiling distinct
		write_reg(REG_FAMILY, 20'd0);
		write_reg(REG_PCLK_16, 20'd90000);
		write_reg(REG_PCLK_32, 20'd200000);
		write_reg(REG_PCLK_32_DH, 20'd60000);
		write_reg(REG_MAX_VCO, 20'd400000);
		send_request(20'd150000, DEPTH_16, 1);
		send_request(20'd150000, DEPTH_32, 1);
		send_request(20'd150000, DEPTH_32, 0);
		send_request(20'd150000, 2'd2, 1);
		send_request(20'd40000, DEPTH_32, 1);
		drain();

		// zero reference, then extremes
		write_reg(REG_REF_CLK, 20'd0);
		send_request(20'd50000, DEPTH_16, 0);
		drain();
		write_reg(REG_REF_CLK, 20'd100000);
		write_reg(REG_MIN_VCO, 20'd0);
		write_reg(REG_MAX_VCO, 20'hFFFFF);
		write_reg(REG_PCLK_16, 20'hFFFFF);
		write_reg(3'd7, 20'd5);
		send_request(20'hFFFFF, DEPTH_16, 0);
		send_request(20'd1, DEPTH_16, 0);
		send_request(20'd0, DEPTH_16, 1);
		drain();
		write_reg(REG_REF_CLK, 20'd1000);
		write_reg(REG_MIN_VCO, 20'hFFFFF);
		send_request(20'd30000, DEPTH_16, 0);
		drain();
		write_reg(REG_MIN_VCO, 20'd0);
		write_reg(REG_PCLK_16, 20'd0);
		send_request(20'd30000, DEPTH_16, 0);
		drain();

		// random phases
		for (int ph = 0; ph < 5; ph++) begin
			write_reg(REG_FAMILY, 20'($urandom_range(0, 1)));
			write_reg(REG_REF_CLK, (ph == 0) ? 20'd27000 : 20'($urandom_range(1000, 100000)));
			write_reg(REG_MIN_VCO, 20'($urandom_range(20000, 100000)));
			write_reg(REG_MAX_VCO, 20'($urandom_range(200000, 500000)));
			write_reg(REG_PCLK_16, 20'($urandom_range(50000, 300000)));
			write_reg(REG_PCLK_32, 20'($urandom_range(50000, 300000)));
			write_reg(REG_PCLK_32_DH, 20'($urandom_range(50000, 300000)));
			if (ph == 4) rx_quiet = 1;
			for (int i = 0; i < 26; i++) random_request();
			rx_quiet = 0;
			drain();
		end

		$display("covered %0d requests over several register settings, %0d results checked",
			n_req, sb.checked);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#20000000;
		$display("timeout");
		$display("end of test: mismatches");
		$finish;
	end
endmodule

>>> sim.f
hw/rtl/pmsl_pkg.sv
hw/rtl/pmsl_div.sv
hw/rtl/pmsl_dp.sv
hw/rtl/pmsl_ctrl.sv
hw/rtl/pll_mnp_search_legacy.sv
sim/tb_top.sv
